@@ rtl/core/dns_response_address_extractor_macros.svh @@
// ----------------------------------------------------------------------------
// DNS response address extractor - assertion macros
// Concurrent assertion shorthands clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_MACROS_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define DRA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dra assertion failed");

// Next-cycle implication
`define DRA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dra assertion failed");

`else

`define DRA_ASSERT_NOW(lbl, ante, cons)
`define DRA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/dra_pkg.sv @@
// ----------------------------------------------------------------------------
// dra_pkg
// Types, codes and constants shared by the DNS response address extractor.
// ----------------------------------------------------------------------------
package dra_pkg;

   // Buffer size default: bytes at or beyond this position are not parsed
   localparam int MAX_PACKET_DEFAULT = 1024;

   // Result queue depth (power of two)
   localparam int RES_FIFO_DEPTH = 4;

   // Register indexes on the configuration port
   localparam logic CSR_EXPECTED_ID = 1'b0;
   localparam logic CSR_NAME_LIMIT  = 1'b1;

   localparam logic [15:0] EXPECTED_ID_RESET = 16'h0000;
   localparam logic [7:0]  NAME_LIMIT_RESET  = 8'd128;

   // Protocol constants
   localparam logic [15:0] FLAGS_MASK   = 16'hfb7f;
   localparam logic [15:0] FLAGS_RESP   = 16'h8100;
   localparam logic [7:0]  PTR_MASK     = 8'hc0;
   localparam logic [15:0] RRTYPE_A     = 16'h0001;
   localparam logic [15:0] RRTYPE_CNAME = 16'h0005;

   // Result kinds
   localparam logic [2:0] KIND_ADDRESS   = 3'd0;
   localparam logic [2:0] KIND_CNAME     = 3'd1;
   localparam logic [2:0] KIND_ACCEPTED  = 3'd2;
   localparam logic [2:0] KIND_IGNORED   = 3'd3;
   localparam logic [2:0] KIND_MALFORMED = 3'd4;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QNAME  = 4'd1,
      PH_QLABEL = 4'd2,
      PH_QFIXED = 4'd3,
      PH_ANAME  = 4'd4,
      PH_ALABEL = 4'd5,
      PH_APTR   = 4'd6,
      PH_AFIXED = 4'd7,
      PH_RDATA  = 4'd8,
      PH_SKIP   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      V_PENDING   = 2'd0,
      V_ACCEPTED  = 2'd1,
      V_IGNORED   = 2'd2,
      V_MALFORMED = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] address;
      logic        final_res;
   } rsp_payload_type;

   // Results of one parsed byte: optional record result, optional closing status
   typedef struct packed {
      logic            rec_vld;
      rsp_payload_type rec;
      logic            fin_vld;
      rsp_payload_type fin;
   } dra_results_type;

endpackage

@@ rtl/core/dra_parser.sv @@
// ----------------------------------------------------------------------------
// dra_parser
// Byte-wise DNS response walker: header checks, question skip, answer walk,
// A record address and CNAME notices, closing status on the last byte.
// ----------------------------------------------------------------------------
module dra_parser #(
   parameter int MAX_PACKET = dra_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  dra_pkg::req_payload_type in_data,
   input  logic [15:0]             expected_id,
   input  logic [7:0]              name_limit,
   output dra_pkg::dra_results_type results
);
   import dra_pkg::*;

   localparam int IDX_W = $clog2(MAX_PACKET + 1);
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_PACKET);

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0]      header_word_ff, header_word_in;
   logic [15:0]      questions_ff, questions_in;
   logic [15:0]      answers_ff, answers_in;
   logic [7:0]       plain_len_ff, plain_len_in;
   logic [5:0]       label_left_ff, label_left_in;
   logic [3:0]       fixed_cnt_ff, fixed_cnt_in;
   logic [15:0]      rtype_ff, rtype_in;
   logic [15:0]      rdata_left_ff, rdata_left_in;
   logic [31:0]      addr_shift_ff, addr_shift_in;
   verdict_type      verdict_ff, verdict_in;

   logic [7:0]  b;
   logic [15:0] hw_new;
   logic [8:0]  name_sum;
   logic        name_fits;
   logic        is_ptr;
   logic [3:0]  fixed_inc;
   logic [15:0] rtype_new;
   logic [15:0] rdl_new;
   logic [15:0] rdl_dec;
   logic [15:0] ans_dec;
   logic [15:0] q_dec;
   logic [5:0]  label_dec;

   // Datapath helpers
   assign b         = in_data.data_byte;
   assign hw_new    = {header_word_ff[7:0], b};
   assign name_sum  = {1'b0, plain_len_ff} + {1'b0, b} + 9'd1;
   assign name_fits = name_sum <= {1'b0, name_limit};
   assign is_ptr    = (b & PTR_MASK) != 8'h00;
   assign fixed_inc = fixed_cnt_ff + 4'd1;
   assign rtype_new = (fixed_cnt_ff < 4'd2) ? {rtype_ff[7:0], b} : rtype_ff;
   assign rdl_new   = (fixed_cnt_ff >= 4'd8) ? {rdata_left_ff[7:0], b} : rdata_left_ff;
   assign rdl_dec   = rdata_left_ff - 16'd1;
   assign ans_dec   = answers_ff - 16'd1;
   assign q_dec     = questions_ff - 16'd1;
   assign label_dec = label_left_ff - 6'd1;

   // Next state and results for one byte
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      header_word_in = header_word_ff;
      questions_in   = questions_ff;
      answers_in     = answers_ff;
      plain_len_in   = plain_len_ff;
      label_left_in  = label_left_ff;
      fixed_cnt_in   = fixed_cnt_ff;
      rtype_in       = rtype_ff;
      rdata_left_in  = rdata_left_ff;
      addr_shift_in  = addr_shift_ff;
      verdict_in     = verdict_ff;
      results        = '0;

      if (go) begin
         if (byte_index_ff < IDX_LIMIT) begin
            byte_index_in = byte_index_ff + IDX_W'(1);
            unique case (phase_ff)
               PH_HEADER: begin
                  header_word_in = hw_new;
                  if (byte_index_ff == IDX_W'(1)) begin
                     if (hw_new != expected_id) verdict_in = V_IGNORED;
                  end else if (byte_index_ff == IDX_W'(3)) begin
                     if ((hw_new & FLAGS_MASK) != FLAGS_RESP) verdict_in = V_IGNORED;
                  end else if (byte_index_ff == IDX_W'(5)) begin
                     questions_in = hw_new;
                  end else if (byte_index_ff == IDX_W'(7)) begin
                     answers_in = hw_new;
                     if (hw_new == 16'd0) verdict_in = V_IGNORED;
                  end else if (byte_index_ff == IDX_W'(11)) begin
                     plain_len_in = 8'd0;
                     if (verdict_ff == V_IGNORED) phase_in = PH_SKIP;
                     else if (questions_ff != 16'd0) phase_in = PH_QNAME;
                     else phase_in = PH_ANAME;
                  end
               end
               PH_QNAME, PH_ANAME: begin
                  if (b == 8'd0) begin
                     fixed_cnt_in = 4'd0;
                     phase_in = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                  end else if (is_ptr) begin
                     // pointer: malformed in a question, ends the name in an answer
                     if (phase_ff == PH_QNAME) begin
                        verdict_in = V_MALFORMED;
                        phase_in   = PH_SKIP;
                     end else begin
                        phase_in = PH_APTR;
                     end
                  end else if (!name_fits) begin
                     verdict_in = V_MALFORMED;
                     phase_in   = PH_SKIP;
                  end else begin
                     plain_len_in  = name_sum[7:0];
                     label_left_in = b[5:0];
                     phase_in = (phase_ff == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                  end
               end
               PH_QLABEL, PH_ALABEL: begin
                  label_left_in = label_dec;
                  if (label_dec == 6'd0)
                     phase_in = (phase_ff == PH_QLABEL) ? PH_QNAME : PH_ANAME;
               end
               PH_QFIXED: begin
                  fixed_cnt_in = fixed_inc;
                  if (fixed_inc == 4'd4) begin
                     questions_in = q_dec;
                     plain_len_in = 8'd0;
                     phase_in = (q_dec == 16'd0) ? PH_ANAME : PH_QNAME;
                  end
               end
               PH_APTR: begin
                  fixed_cnt_in = 4'd0;
                  phase_in     = PH_AFIXED;
               end
               PH_AFIXED: begin
                  rtype_in      = rtype_new;
                  rdata_left_in = rdl_new;
                  fixed_cnt_in  = fixed_inc;
                  if (fixed_inc == 4'd10) begin
                     fixed_cnt_in  = 4'd0;
                     addr_shift_in = 32'd0;
                     if (rtype_new == RRTYPE_A && rdl_new < 16'd4) begin
                        // short A rdata
                        verdict_in = V_MALFORMED;
                        phase_in   = PH_SKIP;
                     end else begin
                        if (rdl_new == 16'd0) begin
                           answers_in = ans_dec;
                           if (ans_dec == 16'd0) begin
                              verdict_in = V_ACCEPTED;
                              phase_in   = PH_SKIP;
                           end else begin
                              phase_in     = PH_ANAME;
                              plain_len_in = 8'd0;
                           end
                        end else begin
                           phase_in = PH_RDATA;
                        end
                        if (rtype_new == RRTYPE_CNAME) begin
                           results.rec_vld       = 1'b1;
                           results.rec.kind      = KIND_CNAME;
                           results.rec.address   = 32'd0;
                           results.rec.final_res = 1'b0;
                        end
                     end
                  end
               end
               PH_RDATA: begin
                  if (rtype_ff == RRTYPE_A && fixed_cnt_ff < 4'd4) begin
                     addr_shift_in = {addr_shift_ff[23:0], b};
                     fixed_cnt_in  = fixed_inc;
                     if (fixed_inc == 4'd4) begin
                        results.rec_vld       = 1'b1;
                        results.rec.kind      = KIND_ADDRESS;
                        results.rec.address   = {addr_shift_ff[23:0], b};
                        results.rec.final_res = 1'b0;
                     end
                  end
                  rdata_left_in = rdl_dec;
                  if (rdl_dec == 16'd0) begin
                     answers_in = ans_dec;
                     if (ans_dec == 16'd0) begin
                        verdict_in = V_ACCEPTED;
                        phase_in   = PH_SKIP;
                     end else begin
                        phase_in     = PH_ANAME;
                        plain_len_in = 8'd0;
                     end
                  end
               end
               PH_SKIP: begin
               end
               default: begin
               end
            endcase
         end

         // Last byte: closing status from the verdict after this byte,
         // then back to a clean header state
         if (in_data.packet_end) begin
            results.fin_vld = 1'b1;
            unique case (verdict_in)
               V_ACCEPTED: results.fin.kind = KIND_ACCEPTED;
               V_IGNORED:  results.fin.kind = KIND_IGNORED;
               default:    results.fin.kind = KIND_MALFORMED;
            endcase
            results.fin.address   = 32'd0;
            results.fin.final_res = 1'b1;
            phase_in       = PH_HEADER;
            byte_index_in  = '0;
            header_word_in = 16'd0;
            questions_in   = 16'd0;
            answers_in     = 16'd0;
            plain_len_in   = 8'd0;
            label_left_in  = 6'd0;
            fixed_cnt_in   = 4'd0;
            rtype_in       = 16'd0;
            rdata_left_in  = 16'd0;
            addr_shift_in  = 32'd0;
            verdict_in     = V_PENDING;
         end
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         byte_index_ff  <= '0;
         header_word_ff <= 16'd0;
         questions_ff   <= 16'd0;
         answers_ff     <= 16'd0;
         plain_len_ff   <= 8'd0;
         label_left_ff  <= 6'd0;
         fixed_cnt_ff   <= 4'd0;
         rtype_ff       <= 16'd0;
         rdata_left_ff  <= 16'd0;
         addr_shift_ff  <= 32'd0;
         verdict_ff     <= V_PENDING;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         header_word_ff <= header_word_in;
         questions_ff   <= questions_in;
         answers_ff     <= answers_in;
         plain_len_ff   <= plain_len_in;
         label_left_ff  <= label_left_in;
         fixed_cnt_ff   <= fixed_cnt_in;
         rtype_ff       <= rtype_in;
         rdata_left_ff  <= rdata_left_in;
         addr_shift_ff  <= addr_shift_in;
         verdict_ff     <= verdict_in;
      end
   end

`include "dns_response_address_extractor_macros.svh"

   // A final verdict always parks the walker in the skip phase
   `DRA_ASSERT_NOW(a_verdict_skip, (verdict_ff == V_ACCEPTED || verdict_ff == V_MALFORMED), (phase_ff == PH_SKIP))
   // Record results only come out of the fixed part or the rdata
   `DRA_ASSERT_NOW(a_rec_phase, results.rec_vld, (phase_ff == PH_AFIXED || phase_ff == PH_RDATA))
   // After the last byte the walker starts over at the header
   `DRA_ASSERT_NEXT(a_end_clears, (go && in_data.packet_end), (phase_ff == PH_HEADER && byte_index_ff == '0 && verdict_ff == V_PENDING))

endmodule

@@ rtl/core/dra_result_fifo.sv @@
// ----------------------------------------------------------------------------
// dra_result_fifo
// Small result queue: takes up to two results a cycle, hands out one while rsp_stall is low.
// ----------------------------------------------------------------------------
module dra_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  dra_pkg::dra_results_type push,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dra_pkg::rsp_payload_type rsp_payload
);
   import dra_pkg::*;

   localparam int DEPTH = RES_FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_payload_type  store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [PTR_W-1:0] wr_fin;
   logic [1:0]       push_n;
   logic             pop;

   // Two free slots are needed before a byte may be parsed
   assign room        = count_ff <= CNT_W'(DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = store_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   assign push_n = {1'b0, push.rec_vld} + {1'b0, push.fin_vld};
   assign wr_fin = wr_ptr_ff + PTR_W'(push.rec_vld);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the record result goes ahead of the closing status
   always_ff @(posedge clock) begin
      if (push.rec_vld) store_ff[wr_ptr_ff] <= push.rec;
      if (push.fin_vld) store_ff[wr_fin] <= push.fin;
   end

endmodule

@@ rtl/core/dns_response_address_extractor.sv @@
// ----------------------------------------------------------------------------
// dns_response_address_extractor
// Walks a DNS response byte by byte and reports A record addresses, CNAME
// notices and a closing status for each packet.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one packet byte per transfer, packet_end set on the last byte.
//   rsp_*: result transfers; kind says address, CNAME seen, or the closing
//     status (accepted, ignored, malformed) carried with final_res set.
//   csr_*: write expected_id (index 0) and name_limit (index 1) while idle.
// Path: a byte is held in the input register and parsed from there, which
//   loads its results into the queue; they transfer from the queue.
// Throughput: one byte per cycle. The parse stage runs while the result
//   queue has two free slots; a byte that yields a record and the closing
//   status puts both in the queue, and they leave one per cycle.
// Reset: synchronous; clears the walker to the header phase, empties the
//   queue and sets expected_id to 0 and name_limit to 128.
// Stall on rsp: the queue fills, the parse stage holds its byte and
//   req_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module dns_response_address_extractor #(
   parameter int MAX_PACKET = dra_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dra_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dra_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [15:0]              csr_wdata
);
   import dra_pkg::*;

   logic            in_vld_ff, in_vld_in;
   req_payload_type in_data_ff;
   logic [15:0]     expected_id_ff, expected_id_in;
   logic [7:0]      name_limit_ff, name_limit_in;

   logic            accept;
   logic            go;
   logic            room;
   dra_results_type results;

   // Input register handshake
   assign go        = in_vld_ff && room;
   assign req_stall = in_vld_ff && !go;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) in_vld_in = 1'b1;
      else if (go) in_vld_in = 1'b0;
      else in_vld_in = in_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (accept) in_data_ff <= req_payload;
   end

   // Configuration registers
   always_comb begin
      expected_id_in = expected_id_ff;
      name_limit_in  = name_limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EXPECTED_ID: expected_id_in = csr_wdata;
            CSR_NAME_LIMIT:  name_limit_in  = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= EXPECTED_ID_RESET;
         name_limit_ff  <= NAME_LIMIT_RESET;
      end else begin
         expected_id_ff <= expected_id_in;
         name_limit_ff  <= name_limit_in;
      end
   end

   // Packet walker
   dra_parser #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .in_data     (in_data_ff),
      .expected_id (expected_id_ff),
      .name_limit  (name_limit_ff),
      .results     (results)
   );

   // Result queue towards the rsp channel
   dra_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (results),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/tb_dns_response_address_extractor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_response_address_extractor
// Streams DNS responses into the extractor one byte per transfer and works
// out every address, CNAME notice and closing status as each byte is taken.
// Results are compared field by field, in order, while in some phases the
// channels idle at random and the result side is held off for long stretches.
// ----------------------------------------------------------------------------
module tb_dns_response_address_extractor;
   import dra_pkg::*;

   localparam int          CLOCK_HALF             = 10;
   localparam int          RESET_CYCLES           = 8;
   localparam int          CYCLE_LIMIT            = 200000;
   localparam int          PHASE_COUNT            = 6;
   localparam int          RANDOM_BYTES_PER_PHASE = 60;
   localparam int          HOLD_CYCLES            = 150;
   localparam int          DRAIN_CYCLES           = 4;
   localparam int          MAX_PRINTED            = 100;
   localparam int          BIG_RDLEN              = 1100;
   localparam int          BUFFER_BYTES           = MAX_PACKET_DEFAULT;
   localparam logic [15:0] FLAGS_FREE             = ~FLAGS_MASK;
   localparam logic [15:0] RRTYPE_AAAA            = 16'h001c;
   localparam int          FILL_RANDOM            = 0;
   localparam int          FILL_ZERO              = 1;
   localparam int          FILL_ONES              = 2;

   // DUT ports
   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_index   = 1'b0;
   logic [15:0]     csr_wdata   = '0;

   // Stimulus and pacing
   req_payload_type byte_queue[$];
   logic [7:0]      pkt[$];
   int              queued_bytes   = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   logic            hold_arm       = 1'b0;
   int              hold_left      = 0;
   int              cycle_count    = 0;
   int              mismatch_count = 0;

   // Response walker: registers, per-packet state and results still to come
   logic [15:0]     want_id;
   int              max_name;
   phase_type       walk_phase;
   int              pos;
   logic [15:0]     hdr_word;
   logic [15:0]     q_left;
   logic [15:0]     a_left;
   int              name_len;
   logic [5:0]      label_left;
   logic [3:0]      fixed_cnt;
   logic [15:0]     rr_type;
   logic [15:0]     rd_left;
   logic [31:0]     addr_acc;
   verdict_type     verdict;
   rsp_payload_type awaited_results[$];

   dns_response_address_extractor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // ------------------------------------------------------------------------
   // Response walker
   // ------------------------------------------------------------------------
   task automatic clear_walk();
      walk_phase = PH_HEADER;
      pos        = 0;
      hdr_word   = '0;
      q_left     = '0;
      a_left     = '0;
      name_len   = 0;
      label_left = '0;
      fixed_cnt  = '0;
      rr_type    = '0;
      rd_left    = '0;
      addr_acc   = '0;
      verdict    = V_PENDING;
   endtask

   task automatic mark_malformed();
      verdict    = V_MALFORMED;
      walk_phase = PH_SKIP;
   endtask

   task automatic finish_answer();
      a_left = a_left - 16'd1;
      if (a_left == 0) begin
         verdict    = V_ACCEPTED;
         walk_phase = PH_SKIP;
      end else begin
         walk_phase = PH_ANAME;
         name_len   = 0;
      end
   endtask

   // Advance the walker by one byte and queue the results it gives
   task automatic walk_byte(input logic [7:0] b, input logic last);
      logic            rec_hit;
      rsp_payload_type rec;
      rsp_payload_type fin;
      rec_hit = 1'b0;
      rec     = '0;
      fin     = '0;
      if (pos < BUFFER_BYTES) begin
         case (walk_phase)
            PH_HEADER: begin
               hdr_word = {hdr_word[7:0], b};
               case (pos)
                  1: if (hdr_word != want_id) verdict = V_IGNORED;
                  3: if ((hdr_word & FLAGS_MASK) != FLAGS_RESP) verdict = V_IGNORED;
                  5: q_left = hdr_word;
                  7: begin
                     a_left = hdr_word;
                     if (a_left == 0) verdict = V_IGNORED;
                  end
                  11: begin
                     name_len = 0;
                     if (verdict == V_IGNORED) walk_phase = PH_SKIP;
                     else walk_phase = (q_left != 0) ? PH_QNAME : PH_ANAME;
                  end
                  default: ;
               endcase
            end
            PH_QNAME, PH_ANAME: begin
               if (b == 8'h00) begin
                  fixed_cnt  = '0;
                  walk_phase = (walk_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
               end else if ((b & PTR_MASK) != 0) begin
                  // compression pointer: not allowed in questions, ends an answer name
                  if (walk_phase == PH_QNAME) mark_malformed();
                  else walk_phase = PH_APTR;
               end else if (name_len + int'(b) + 1 > max_name) begin
                  mark_malformed();
               end else begin
                  name_len   = name_len + int'(b) + 1;
                  label_left = b[5:0];
                  walk_phase = (walk_phase == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
               end
            end
            PH_QLABEL, PH_ALABEL: begin
               label_left = label_left - 6'd1;
               if (label_left == 0)
                  walk_phase = (walk_phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
            end
            PH_QFIXED: begin
               fixed_cnt = fixed_cnt + 4'd1;
               if (fixed_cnt == 4) begin
                  q_left     = q_left - 16'd1;
                  name_len   = 0;
                  walk_phase = (q_left == 0) ? PH_ANAME : PH_QNAME;
               end
            end
            PH_APTR: begin
               fixed_cnt  = '0;
               walk_phase = PH_AFIXED;
            end
            PH_AFIXED: begin
               // type, class, ttl, rdlength
               if (fixed_cnt < 2) rr_type = {rr_type[7:0], b};
               else if (fixed_cnt >= 8) rd_left = {rd_left[7:0], b};
               fixed_cnt = fixed_cnt + 4'd1;
               if (fixed_cnt == 10) begin
                  fixed_cnt = '0;
                  addr_acc  = '0;
                  if (rr_type == RRTYPE_A && rd_left < 4) begin
                     mark_malformed();
                  end else begin
                     if (rd_left == 0) finish_answer();
                     else walk_phase = PH_RDATA;
                     if (rr_type == RRTYPE_CNAME) begin
                        rec_hit  = 1'b1;
                        rec.kind = KIND_CNAME;
                     end
                  end
               end
            end
            PH_RDATA: begin
               if (rr_type == RRTYPE_A && fixed_cnt < 4) begin
                  addr_acc  = {addr_acc[23:0], b};
                  fixed_cnt = fixed_cnt + 4'd1;
                  if (fixed_cnt == 4) begin
                     rec_hit     = 1'b1;
                     rec.kind    = KIND_ADDRESS;
                     rec.address = addr_acc;
                  end
               end
               rd_left = rd_left - 16'd1;
               if (rd_left == 0) finish_answer();
            end
            default: ;
         endcase
         pos = pos + 1;
      end
      if (rec_hit) awaited_results = {awaited_results, rec};
      // closing status follows any record result of the same byte
      if (last) begin
         case (verdict)
            V_ACCEPTED: fin.kind = KIND_ACCEPTED;
            V_IGNORED:  fin.kind = KIND_IGNORED;
            default:    fin.kind = KIND_MALFORMED;
         endcase
         fin.final_res = 1'b1;
         awaited_results = {awaited_results, fin};
         clear_walk();
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result with nothing outstanding, kind", 32'(got.kind), 32'hx);
      end else begin
         want = awaited_results.pop_front();
         if (got.kind != want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
         if (got.address != want.address)
            report_mismatch("address", got.address, want.address);
         if (got.final_res != want.final_res)
            report_mismatch("final_res", 32'(got.final_res), 32'(want.final_res));
      end
   endtask

   // ------------------------------------------------------------------------
   // Packet building
   // ------------------------------------------------------------------------
   task automatic add8(input logic [7:0] v);
      pkt = {pkt, v};
   endtask

   task automatic add16(input logic [15:0] v);
      add8(v[15:8]);
      add8(v[7:0]);
   endtask

   task automatic add_random_bytes(input int n);
      int i;
      for (i = 0; i < n; i++) add8(8'($urandom));
   endtask

   // id, flags, qdcount, ancount, then random nscount and arcount
   task automatic add_header(input logic [15:0] id, input logic [15:0] flags,
                             input logic [15:0] qd, input logic [15:0] an);
      add16(id);
      add16(flags);
      add16(qd);
      add16(an);
      add16(16'($urandom));
      add16(16'($urandom));
   endtask

   // in-line labels, closed by a root byte or a two-byte pointer
   task automatic add_name(input int labels, input int min_len, input int max_len,
                           input bit ptr);
      int i;
      int len;
      for (i = 0; i < labels; i++) begin
         len = $urandom_range(min_len, max_len);
         add8(8'(len));
         add_random_bytes(len);
      end
      if (ptr) begin
         add8(8'($urandom_range(64, 255)));
         add8(8'($urandom));
      end else begin
         add8(8'h00);
      end
   endtask

   task automatic add_answer(input int labels, input int min_len, input int max_len,
                             input bit ptr, input logic [15:0] rtype, input int rdlen,
                             input int fill);
      int i;
      add_name(labels, min_len, max_len, ptr);
      add16(rtype);
      add_random_bytes(6);
      add16(16'(rdlen));
      for (i = 0; i < rdlen; i++) begin
         case (fill)
            FILL_ZERO: add8(8'h00);
            FILL_ONES: add8(8'hff);
            default:   add8(8'($urandom));
         endcase
      end
   endtask

   // Queue the built packet, cut to keep bytes when keep is nonzero
   task automatic send_packet(input int keep);
      int              i;
      int              n;
      req_payload_type item;
      n = (keep == 0 || keep > pkt.size()) ? pkt.size() : keep;
      for (i = 0; i < n; i++) begin
         item.data_byte  = pkt[i];
         item.packet_end = (i == n - 1);
         byte_queue = {byte_queue, item};
      end
      queued_bytes += n;
      pkt.delete();
   endtask

   task automatic add_directed_packets();
      // two A records with extreme addresses, the last on the final byte
      add_header(want_id, FLAGS_RESP, 1, 2);
      add_name(1, 3, 3, 0);
      add_random_bytes(4);
      add_answer(0, 1, 1, 1, RRTYPE_A, 4, FILL_ONES);
      add_answer(1, 7, 7, 0, RRTYPE_A, 4, FILL_ZERO);
      send_packet(0);
      // wrong transaction id
      add_header(want_id ^ 16'h0001, FLAGS_RESP, 0, 1);
      send_packet(0);
      // don't-care flag bits set, CNAME record
      add_header(want_id, FLAGS_RESP | FLAGS_FREE, 0, 1);
      add_answer(0, 1, 1, 0, RRTYPE_CNAME, 3, FILL_RANDOM);
      send_packet(0);
      // bad flags, packet ends inside the header
      add_header(want_id, 16'h0000, 0, 1);
      send_packet(4);
      // no answers
      add_header(want_id, FLAGS_RESP, 0, 0);
      add_random_bytes(3);
      send_packet(0);
      // pointer inside a question name
      add_header(want_id, FLAGS_RESP, 1, 1);
      add_name(1, 2, 2, 1);
      add_random_bytes(4);
      send_packet(0);
      // label one past the name limit
      add_header(want_id, FLAGS_RESP, 0, 1);
      add_answer(1, 8, 8, 0, RRTYPE_A, 4, FILL_RANDOM);
      send_packet(0);
      // A record with short rdata
      add_header(want_id, FLAGS_RESP, 0, 2);
      add_answer(0, 1, 1, 1, RRTYPE_A, 3, FILL_RANDOM);
      add_answer(0, 1, 1, 1, RRTYPE_A, 4, FILL_RANDOM);
      send_packet(0);
      // other type, empty rdata, then authority bytes
      add_header(want_id, FLAGS_RESP, 0, 1);
      add_answer(0, 1, 1, 1, RRTYPE_AAAA, 0, FILL_RANDOM);
      add_random_bytes(5);
      send_packet(0);
      // A rdata longer than four bytes
      add_header(want_id, FLAGS_RESP, 0, 1);
      add_answer(0, 1, 1, 0, RRTYPE_A, 6, FILL_RANDOM);
      send_packet(0);
      // truncated inside the answer rdata
      add_header(want_id, FLAGS_RESP, 1, 1);
      add_name(2, 1, 2, 0);
      add_random_bytes(4);
      add_answer(0, 1, 1, 1, RRTYPE_A, 4, FILL_RANDOM);
      send_packet(pkt.size() - 2);
      // single-byte packet
      add_random_bytes(1);
      send_packet(0);
      // empty CNAME closes the packet on its rdlength byte
      add_header(want_id, FLAGS_RESP, 2, 1);
      add_name(0, 1, 1, 0);
      add_random_bytes(4);
      add_name(0, 1, 1, 0);
      add_random_bytes(4);
      add_answer(1, 1, 4, 0, RRTYPE_CNAME, 0, FILL_RANDOM);
      send_packet(0);
   endtask

   // Mostly well-formed responses with random content; some noise and cuts
   task automatic add_random_packet();
      int          sel;
      int          qd;
      int          an;
      int          i;
      int          len;
      int          rdlen;
      logic [15:0] id;
      logic [15:0] flags;
      logic [15:0] rtype;
      sel = $urandom_range(99);
      if (sel < 8) begin
         add_random_bytes($urandom_range(1, 24));
         send_packet(0);
      end else begin
         id    = ($urandom_range(9) == 0) ? 16'($urandom) : want_id;
         flags = ($urandom_range(12) == 0) ? 16'($urandom)
                                           : (FLAGS_RESP | (16'($urandom) & FLAGS_FREE));
         qd    = $urandom_range(0, 2);
         an    = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
         add_header(id, flags, 16'(qd), 16'(an));
         for (i = 0; i < qd; i++) begin
            len = ($urandom_range(19) == 0) ? 63 : 6;
            add_name($urandom_range(0, 3), 1, len, $urandom_range(24) == 0);
            add_random_bytes(4);
         end
         for (i = 0; i < an; i++) begin
            sel = $urandom_range(9);
            if (sel < 6) begin
               rtype = RRTYPE_A;
               rdlen = ($urandom_range(6) == 0) ? $urandom_range(0, 8) : 4;
            end else if (sel < 8) begin
               rtype = RRTYPE_CNAME;
               rdlen = $urandom_range(0, 6);
            end else begin
               rtype = 16'($urandom);
               rdlen = $urandom_range(0, 6);
            end
            len = ($urandom_range(19) == 0) ? 63 : 6;
            add_answer($urandom_range(0, 2), 1, len, $urandom_range(1) == 1, rtype, rdlen,
                       FILL_RANDOM);
         end
         if ($urandom_range(4) == 0) add_random_bytes($urandom_range(1, 6));
         send_packet(($urandom_range(9) == 0) ? $urandom_range(1, pkt.size()) : 0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_EXPECTED_ID) want_id = val;
      else max_name = int'(val[7:0]);
   endtask

   // Every byte sent and every result back, then let the pipe drain
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int          phase_no;
      int          start_bytes;
      logic [15:0] id_val;
      int          limit_val;
      want_id  = EXPECTED_ID_RESET;
      max_name = int'(NAME_LIMIT_RESET);
      clear_walk();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
         case (phase_no)
            0: begin
               id_val    = 16'h0000;
               limit_val = 8;
            end
            1: begin
               id_val    = 16'hffff;
               limit_val = 1;
            end
            2: begin
               id_val    = 16'($urandom);
               limit_val = int'(NAME_LIMIT_RESET);
            end
            3: begin
               id_val    = 16'($urandom);
               limit_val = $urandom_range(2, 40);
            end
            4: begin
               id_val    = 16'($urandom);
               limit_val = 255;
            end
            default: begin
               id_val    = 16'($urandom);
               limit_val = $urandom_range(1, 255);
            end
         endcase
         write_reg(CSR_EXPECTED_ID, id_val);
         write_reg(CSR_NAME_LIMIT, 16'(limit_val));

         // sender idles lightly first, then the receiver, then neither
         send_idle_pct = (phase_no < 2) ? 19 : (phase_no < 4) ? 56 : 0;
         recv_idle_pct = (phase_no < 2) ? 56 : (phase_no < 4) ? 19 : 0;

         if (phase_no == 0) begin
            add_directed_packets();
         end else begin
            start_bytes = queued_bytes;
            while (queued_bytes - start_bytes < RANDOM_BYTES_PER_PHASE) add_random_packet();
            // A rdata running past the buffer end
            if (phase_no == 4) begin
               add_header(want_id, FLAGS_RESP, 0, 1);
               add_answer(0, 1, 1, 0, RRTYPE_A, BIG_RDLEN, FILL_RANDOM);
               send_packet(0);
            end
            // long hold-off on results while bytes keep coming
            @(posedge clock);
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES * 4) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Byte driver: next byte from the queue once the last one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            walk_byte(req_payload.data_byte, req_payload.packet_end);
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= byte_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_payload);
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Hold-off counter
   always @(posedge clock) begin
      if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
